FILE: sv/srp_pkg.sv
package srp_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned FIELD_W     = 14;
    localparam int unsigned ERR_W       = 2;
    localparam int unsigned HDR_IDX_W   = 4;
    localparam int unsigned M_TDATA_W   = 32;

    localparam logic [HDR_IDX_W-1:0] HEADER_LEN = 4'd9;
    localparam logic [HDR_IDX_W-1:0] MAGIC_LEN  = 4'd5;

    localparam logic [DATA_W-1:0] AUX_MARK    = 8'hFA;
    localparam logic [DATA_W-1:0] SELECT_DB   = 8'hFE;
    localparam logic [DATA_W-1:0] RESIZE_MARK = 8'hFB;
    localparam logic [DATA_W-1:0] END_MARK    = 8'hFF;
    localparam logic [DATA_W-1:0] TYPE_STRING = 8'h00;
    localparam logic [DATA_W-1:0] DIGIT_ZERO  = 8'h30;
    localparam logic [DATA_W-1:0] DIGIT_NINE  = 8'h39;

    typedef logic [DATA_W-1:0] magic_arr_t [0:4];
    localparam magic_arr_t MAGIC_TEXT = '{8'h52, 8'h45, 8'h44, 8'h49, 8'h53};

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_MAGIC     = 2'd1,
        ERR_VERSION   = 2'd2
    } err_t;

    typedef enum logic [4:0] {
        PH_HEADER, PH_SKIP, PH_AKLEN, PH_AKEY, PH_AVLEN, PH_AVAL,
        PH_DBFIRST, PH_DBINDEX, PH_DBSECOND, PH_HASH, PH_EXPHASH,
        PH_TYPE, PH_EKLEN, PH_EKEY, PH_EVLEN, PH_EVAL, PH_DONE, PH_HALT
    } phase_t;

    typedef enum logic [4:0] {
        ROLE_MAGIC      = 5'd0,
        ROLE_VERSION    = 5'd1,
        ROLE_SKIPPED    = 5'd2,
        ROLE_AUX_MARK   = 5'd3,
        ROLE_AUX_KLEN   = 5'd4,
        ROLE_AUX_KEY    = 5'd5,
        ROLE_AUX_VLEN   = 5'd6,
        ROLE_AUX_VAL    = 5'd7,
        ROLE_DB_FIRST   = 5'd8,
        ROLE_DB_INDEX   = 5'd9,
        ROLE_SECOND     = 5'd10,
        ROLE_HASH       = 5'd11,
        ROLE_EXPHASH    = 5'd12,
        ROLE_TYPE       = 5'd13,
        ROLE_ENT_KLEN   = 5'd14,
        ROLE_ENT_KEY    = 5'd15,
        ROLE_ENT_VLEN   = 5'd16,
        ROLE_ENT_VAL    = 5'd17,
        ROLE_UNKNOWN    = 5'd18,
        ROLE_END        = 5'd19,
        ROLE_IGNORED    = 5'd20
    } role_t;

    typedef struct packed {
        role_t                  byte_role;
        logic [DATA_W-1:0]      byte_value;
        logic [FIELD_W-1:0]     field_value;
        err_t                   error_code;
        logic                   parse_done;
    } result_t;

endpackage

FILE: sv/srp_parse_core.sv
module srp_parse_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             byte_fire,
    input  logic [srp_pkg::DATA_W-1:0]       data_byte,
    output srp_pkg::result_t                 result
);

    srp_pkg::phase_t                    phase_reg, phase_next;
    logic [srp_pkg::DATA_W-1:0]         left_reg, left_next;
    logic [srp_pkg::HDR_IDX_W-1:0]      hidx_reg, hidx_next;
    logic                               magic_ok_reg, magic_ok_next;
    logic [srp_pkg::FIELD_W-1:0]        vers_reg, vers_next;
    logic                               digits_ok_reg, digits_ok_next;
    srp_pkg::err_t                      err_reg, err_next;

    srp_pkg::role_t                     role;
    logic [srp_pkg::FIELD_W-1:0]        field;
    logic [srp_pkg::DATA_W-1:0]         left_dec;
    logic [3:0]                         digit;
    logic                               is_digit;

    assign left_dec = left_reg - 1'b1;
    assign digit    = 4'(data_byte - srp_pkg::DIGIT_ZERO);
    assign is_digit = (data_byte >= srp_pkg::DIGIT_ZERO) && (data_byte <= srp_pkg::DIGIT_NINE);

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        hidx_next      = hidx_reg;
        magic_ok_next  = magic_ok_reg;
        vers_next      = vers_reg;
        digits_ok_next = digits_ok_reg;
        err_next       = err_reg;
        role           = srp_pkg::ROLE_IGNORED;
        field          = '0;

        unique case (phase_reg)
            srp_pkg::PH_HEADER:
            begin
                if (hidx_reg < srp_pkg::MAGIC_LEN)
                begin
                    role = srp_pkg::ROLE_MAGIC;
                    if (data_byte != srp_pkg::MAGIC_TEXT[hidx_reg[2:0]])
                    begin
                        magic_ok_next = 1'b0;
                    end
                end
                else
                begin
                    role = srp_pkg::ROLE_VERSION;
                    if (is_digit)
                    begin
                        // times ten as two shifts
                        vers_next = (vers_reg << 3) + (vers_reg << 1)
                                    + {{(srp_pkg::FIELD_W-4){1'b0}}, digit};
                    end
                    else
                    begin
                        digits_ok_next = 1'b0;
                    end
                end
                hidx_next = hidx_reg + 1'b1;
                if (hidx_next >= srp_pkg::HEADER_LEN)
                begin
                    if (!magic_ok_next)
                    begin
                        err_next   = srp_pkg::ERR_MAGIC;
                        phase_next = srp_pkg::PH_HALT;
                    end
                    else if (!digits_ok_next)
                    begin
                        err_next   = srp_pkg::ERR_VERSION;
                        phase_next = srp_pkg::PH_HALT;
                    end
                    else
                    begin
                        phase_next = srp_pkg::PH_SKIP;
                    end
                    field = digits_ok_next ? vers_next : '0;
                end
            end
            srp_pkg::PH_SKIP:
            begin
                if (data_byte == srp_pkg::AUX_MARK)
                begin
                    role       = srp_pkg::ROLE_AUX_MARK;
                    phase_next = srp_pkg::PH_AKLEN;
                end
                else
                begin
                    role = srp_pkg::ROLE_SKIPPED;
                end
            end
            srp_pkg::PH_AKLEN, srp_pkg::PH_EKLEN:
            begin
                field     = {{(srp_pkg::FIELD_W-srp_pkg::DATA_W){1'b0}}, data_byte};
                left_next = data_byte;
                if (phase_reg == srp_pkg::PH_AKLEN)
                begin
                    role       = srp_pkg::ROLE_AUX_KLEN;
                    phase_next = (data_byte != '0) ? srp_pkg::PH_AKEY : srp_pkg::PH_AVLEN;
                end
                else
                begin
                    role       = srp_pkg::ROLE_ENT_KLEN;
                    phase_next = (data_byte != '0) ? srp_pkg::PH_EKEY : srp_pkg::PH_EVLEN;
                end
            end
            srp_pkg::PH_AKEY, srp_pkg::PH_EKEY:
            begin
                left_next = left_dec;
                if (phase_reg == srp_pkg::PH_AKEY)
                begin
                    role = srp_pkg::ROLE_AUX_KEY;
                    if (left_dec == '0)
                    begin
                        phase_next = srp_pkg::PH_AVLEN;
                    end
                end
                else
                begin
                    role = srp_pkg::ROLE_ENT_KEY;
                    if (left_dec == '0)
                    begin
                        phase_next = srp_pkg::PH_EVLEN;
                    end
                end
            end
            srp_pkg::PH_AVLEN, srp_pkg::PH_EVLEN:
            begin
                field     = {{(srp_pkg::FIELD_W-srp_pkg::DATA_W){1'b0}}, data_byte};
                left_next = data_byte;
                if (phase_reg == srp_pkg::PH_AVLEN)
                begin
                    role       = srp_pkg::ROLE_AUX_VLEN;
                    phase_next = (data_byte != '0) ? srp_pkg::PH_AVAL : srp_pkg::PH_DBFIRST;
                end
                else
                begin
                    role       = srp_pkg::ROLE_ENT_VLEN;
                    phase_next = (data_byte != '0) ? srp_pkg::PH_EVAL : srp_pkg::PH_TYPE;
                end
            end
            srp_pkg::PH_AVAL, srp_pkg::PH_EVAL:
            begin
                left_next = left_dec;
                if (phase_reg == srp_pkg::PH_AVAL)
                begin
                    role = srp_pkg::ROLE_AUX_VAL;
                    if (left_dec == '0)
                    begin
                        phase_next = srp_pkg::PH_DBFIRST;
                    end
                end
                else
                begin
                    role = srp_pkg::ROLE_ENT_VAL;
                    if (left_dec == '0)
                    begin
                        phase_next = srp_pkg::PH_TYPE;
                    end
                end
            end
            srp_pkg::PH_DBFIRST:
            begin
                role       = srp_pkg::ROLE_DB_FIRST;
                phase_next = (data_byte == srp_pkg::SELECT_DB) ? srp_pkg::PH_DBINDEX
                                                               : srp_pkg::PH_DBSECOND;
            end
            srp_pkg::PH_DBINDEX:
            begin
                role       = srp_pkg::ROLE_DB_INDEX;
                field      = {{(srp_pkg::FIELD_W-srp_pkg::DATA_W){1'b0}}, data_byte};
                phase_next = srp_pkg::PH_DBSECOND;
            end
            srp_pkg::PH_HASH:
            begin
                role       = srp_pkg::ROLE_HASH;
                field      = {{(srp_pkg::FIELD_W-srp_pkg::DATA_W){1'b0}}, data_byte};
                phase_next = srp_pkg::PH_EXPHASH;
            end
            srp_pkg::PH_EXPHASH:
            begin
                role       = srp_pkg::ROLE_EXPHASH;
                field      = {{(srp_pkg::FIELD_W-srp_pkg::DATA_W){1'b0}}, data_byte};
                phase_next = srp_pkg::PH_TYPE;
            end
            srp_pkg::PH_DBSECOND, srp_pkg::PH_TYPE:
            begin
                // a non-resize second byte is read as a type byte straight away
                if ((phase_reg == srp_pkg::PH_DBSECOND) && (data_byte == srp_pkg::RESIZE_MARK))
                begin
                    role       = srp_pkg::ROLE_SECOND;
                    phase_next = srp_pkg::PH_HASH;
                end
                else if (data_byte == srp_pkg::END_MARK)
                begin
                    role       = srp_pkg::ROLE_END;
                    phase_next = srp_pkg::PH_DONE;
                end
                else if (data_byte == srp_pkg::TYPE_STRING)
                begin
                    role       = srp_pkg::ROLE_TYPE;
                    phase_next = srp_pkg::PH_EKLEN;
                end
                else
                begin
                    role       = srp_pkg::ROLE_UNKNOWN;
                    phase_next = srp_pkg::PH_TYPE;
                end
            end
            default:
            begin
                role = srp_pkg::ROLE_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= srp_pkg::PH_HEADER;
            left_reg      <= '0;
            hidx_reg      <= '0;
            magic_ok_reg  <= 1'b1;
            vers_reg      <= '0;
            digits_ok_reg <= 1'b1;
            err_reg       <= srp_pkg::ERR_NONE;
        end
        else if (byte_fire)
        begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            hidx_reg      <= hidx_next;
            magic_ok_reg  <= magic_ok_next;
            vers_reg      <= vers_next;
            digits_ok_reg <= digits_ok_next;
            err_reg       <= err_next;
        end
    end

    always_comb
    begin
        result.byte_role   = role;
        result.byte_value  = data_byte;
        result.field_value = field;
        result.error_code  = err_next;
        result.parse_done  = (phase_next == srp_pkg::PH_DONE);
    end

endmodule

FILE: sv/srp_out_skid.sv
module srp_out_skid
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  srp_pkg::result_t    in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output srp_pkg::result_t    out_word
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    srp_pkg::result_t   out_word_reg, out_word_next;
    srp_pkg::result_t   skid_word_reg, skid_word_next;
    logic               in_fire;
    logic               out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_word_next  = in_word;
            end
        end
        else if (in_fire)
        begin
            // output stalled: park the new word
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: sv/snapshot_record_parser.sv
// channel   dir  tdata                                        tuser
// s_        in   data_byte[7:0]                               -
// m_        out  byte_value[7:0] field_value[21:8]            byte_role[4:0]
//                error_code[23:22] parse_done[24]
//
// one byte per cycle while the skid stage is empty
// parse state is updated at the byte handshake, the result lands in an output
// register backed by a one-word skid stage
// s_tready drops only while the skid stage holds a word
// rst_n clears the parse state to the first header byte and empties both stages
module snapshot_record_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // byte_value[7:0], field_value[21:8], error_code[23:22],
                                    // parse_done[24], zero fill
    output logic [4:0]  m_tuser     // byte_role[4:0]
);

    srp_pkg::result_t   core_word;
    srp_pkg::result_t   out_word;
    logic               byte_fire;

    assign byte_fire = s_tvalid && s_tready;

    srp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .data_byte (s_tdata),
        .result    (core_word)
    );

    srp_out_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (core_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tuser = out_word.byte_role;
    assign m_tdata = {{(srp_pkg::M_TDATA_W - 25){1'b0}},
                      out_word.parse_done,
                      out_word.error_code,
                      out_word.field_value,
                      out_word.byte_value};

    // a stalled output that takes a new word must fill the skid stage
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tvalid && !m_tready) |=> !s_tready)
        else $error("stalled output took a word without holding it");

    // an error halts the parse, so the end marker can never be reported with it
    a_err_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[23:22] != srp_pkg::ERR_NONE)) |-> !m_tdata[24])
        else $error("parse_done set together with an error");

    // once done, every later word is an ignored byte that stays done
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata[24] && (m_tuser != srp_pkg::ROLE_END)) |->
        (m_tuser == srp_pkg::ROLE_IGNORED))
        else $error("byte after the end marker not ignored");

endmodule

FILE: dv/tb_snapshot_record_parser.sv
`timescale 1ns / 1ps

module tb_snapshot_record_parser;

    import srp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // data_byte[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // byte_value[7:0], field_value[21:8], error_code[23:22],
                              // parse_done[24], zero fill
    logic [4:0]  m_tuser;     // byte_role[4:0]

    snapshot_record_parser uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        role_t       role;
        logic [13:0] fld;
    } stim_row_t;

    localparam int N_DIRECTED = 26;

    // header with the largest version, skipped bytes, aux pair, select and resize with
    // extreme sizes, an unknown type, then an entry with zero key and value lengths
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{MAGIC_TEXT[0], 1'b1, ROLE_MAGIC,    14'd0},
        '{MAGIC_TEXT[1], 1'b1, ROLE_MAGIC,    14'd0},
        '{MAGIC_TEXT[2], 1'b1, ROLE_MAGIC,    14'd0},
        '{MAGIC_TEXT[3], 1'b1, ROLE_MAGIC,    14'd0},
        '{MAGIC_TEXT[4], 1'b1, ROLE_MAGIC,    14'd0},
        '{DIGIT_NINE,    1'b1, ROLE_VERSION,  14'd0},
        '{DIGIT_NINE,    1'b1, ROLE_VERSION,  14'd0},
        '{DIGIT_NINE,    1'b1, ROLE_VERSION,  14'd0},
        '{DIGIT_NINE,    1'b1, ROLE_VERSION,  14'd9999},
        '{8'h00,         1'b0, ROLE_SKIPPED,  14'd0},
        '{END_MARK,      1'b0, ROLE_SKIPPED,  14'd0},
        '{SELECT_DB,     1'b0, ROLE_SKIPPED,  14'd0},
        '{AUX_MARK,      1'b1, ROLE_AUX_MARK, 14'd0},
        '{8'd1,          1'b0, ROLE_AUX_KLEN, 14'd0},
        '{8'hFF,         1'b0, ROLE_AUX_KEY,  14'd0},
        '{8'd1,          1'b0, ROLE_AUX_VLEN, 14'd0},
        '{8'h00,         1'b0, ROLE_AUX_VAL,  14'd0},
        '{SELECT_DB,     1'b1, ROLE_DB_FIRST, 14'd0},
        '{8'hFF,         1'b1, ROLE_DB_INDEX, 14'd255},
        '{RESIZE_MARK,   1'b1, ROLE_SECOND,   14'd0},
        '{8'h00,         1'b1, ROLE_HASH,     14'd0},
        '{8'hFF,         1'b1, ROLE_EXPHASH,  14'd255},
        '{8'h5A,         1'b0, ROLE_UNKNOWN,  14'd0},
        '{TYPE_STRING,   1'b0, ROLE_TYPE,     14'd0},
        '{8'd0,          1'b0, ROLE_ENT_KLEN, 14'd0},
        '{8'd0,          1'b0, ROLE_ENT_VLEN, 14'd0}
    };

    // parser shadow state
    phase_t      cur_phase     = PH_HEADER;
    logic [7:0]  len_left      = '0;
    logic [3:0]  hdr_pos       = '0;
    logic        magic_ok      = 1'b1;
    logic [13:0] ver_acc       = '0;
    logic        ver_digits_ok = 1'b1;
    logic [7:0]  main_hash_sz  = '0;
    logic [7:0]  exp_hash_sz   = '0;
    err_t        sticky_err    = ERR_NONE;

    result_t pending_words [$];
    int      err_count     = 0;
    int      bytes_taken   = 0;
    int      words_checked = 0;
    int      entries_sent  = 0;
    int      unknown_sent  = 0;
    int      longest_len   = 0;
    bit      calm          = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic role_t classify_type(input logic [7:0] b, output phase_t nxt);
        if (b == END_MARK)
        begin
            nxt = PH_DONE;
            return ROLE_END;
        end
        if (b == TYPE_STRING)
        begin
            nxt = PH_EKLEN;
            return ROLE_TYPE;
        end
        nxt = PH_TYPE;
        return ROLE_UNKNOWN;
    endfunction

    // works out the word for one accepted byte and advances the shadow state
    function automatic result_t label_byte(input logic [7:0] b);
        result_t     r;
        role_t       role;
        logic [13:0] fld;
        phase_t      nxt;
        role = ROLE_IGNORED;
        fld  = '0;
        case (cur_phase)
            PH_HEADER:
            begin
                if (hdr_pos < MAGIC_LEN)
                begin
                    role = ROLE_MAGIC;
                    if (b != MAGIC_TEXT[hdr_pos])
                        magic_ok = 1'b0;
                end
                else
                begin
                    role = ROLE_VERSION;
                    if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
                        ver_acc = ver_acc * 14'd10 + 14'(b - DIGIT_ZERO);
                    else
                        ver_digits_ok = 1'b0;
                end
                hdr_pos = hdr_pos + 4'd1;
                if (hdr_pos >= HEADER_LEN)
                begin
                    if (!magic_ok)
                    begin
                        sticky_err = ERR_MAGIC;
                        cur_phase  = PH_HALT;
                    end
                    else if (!ver_digits_ok)
                    begin
                        sticky_err = ERR_VERSION;
                        cur_phase  = PH_HALT;
                    end
                    else
                        cur_phase = PH_SKIP;
                    fld = ver_digits_ok ? ver_acc : '0;
                end
            end
            PH_SKIP:
            begin
                if (b == AUX_MARK)
                begin
                    role      = ROLE_AUX_MARK;
                    cur_phase = PH_AKLEN;
                end
                else
                    role = ROLE_SKIPPED;
            end
            PH_AKLEN, PH_EKLEN:
            begin
                role     = (cur_phase == PH_AKLEN) ? ROLE_AUX_KLEN : ROLE_ENT_KLEN;
                fld      = 14'(b);
                len_left = b;
                if (cur_phase == PH_AKLEN)
                    cur_phase = (b != 0) ? PH_AKEY : PH_AVLEN;
                else
                    cur_phase = (b != 0) ? PH_EKEY : PH_EVLEN;
            end
            PH_AKEY, PH_EKEY:
            begin
                role     = (cur_phase == PH_AKEY) ? ROLE_AUX_KEY : ROLE_ENT_KEY;
                len_left = len_left - 8'd1;
                if (len_left == 0)
                    cur_phase = (cur_phase == PH_AKEY) ? PH_AVLEN : PH_EVLEN;
            end
            PH_AVLEN, PH_EVLEN:
            begin
                role     = (cur_phase == PH_AVLEN) ? ROLE_AUX_VLEN : ROLE_ENT_VLEN;
                fld      = 14'(b);
                len_left = b;
                if (cur_phase == PH_AVLEN)
                    cur_phase = (b != 0) ? PH_AVAL : PH_DBFIRST;
                else
                    cur_phase = (b != 0) ? PH_EVAL : PH_TYPE;
            end
            PH_AVAL, PH_EVAL:
            begin
                role     = (cur_phase == PH_AVAL) ? ROLE_AUX_VAL : ROLE_ENT_VAL;
                len_left = len_left - 8'd1;
                if (len_left == 0)
                    cur_phase = (cur_phase == PH_AVAL) ? PH_DBFIRST : PH_TYPE;
            end
            PH_DBFIRST:
            begin
                role      = ROLE_DB_FIRST;
                cur_phase = (b == SELECT_DB) ? PH_DBINDEX : PH_DBSECOND;
            end
            PH_DBINDEX:
            begin
                role      = ROLE_DB_INDEX;
                fld       = 14'(b);
                cur_phase = PH_DBSECOND;
            end
            PH_DBSECOND:
            begin
                if (b == RESIZE_MARK)
                begin
                    role      = ROLE_SECOND;
                    cur_phase = PH_HASH;
                end
                else
                begin
                    role      = classify_type(b, nxt);
                    cur_phase = nxt;
                end
            end
            PH_HASH:
            begin
                role         = ROLE_HASH;
                fld          = 14'(b);
                main_hash_sz = b;
                cur_phase    = PH_EXPHASH;
            end
            PH_EXPHASH:
            begin
                role        = ROLE_EXPHASH;
                fld         = 14'(b);
                exp_hash_sz = b;
                cur_phase   = PH_TYPE;
            end
            PH_TYPE:
            begin
                role      = classify_type(b, nxt);
                cur_phase = nxt;
            end
            default:
                role = ROLE_IGNORED;
        endcase
        r.byte_role   = role;
        r.byte_value  = b;
        r.field_value = fld;
        r.error_code  = sticky_err;
        r.parse_done  = (cur_phase == PH_DONE);
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 90)
            return $urandom_range(1, 8);
        if (r < 98)
            return $urandom_range(9, 40);
        return $urandom_range(200, 255);
    endfunction

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
        clk = 1'b0;

    // output words are checked before the byte taken on the same edge is labelled
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("unexpected word", int'(m_tuser), -1);
                else
                begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (m_tuser != want.byte_role)
                        report_mismatch("byte_role", m_tuser, want.byte_role);
                    if (m_tdata[7:0] != want.byte_value)
                        report_mismatch("byte_value", m_tdata[7:0], want.byte_value);
                    if (m_tdata[21:8] != want.field_value)
                        report_mismatch("field_value", m_tdata[21:8], want.field_value);
                    if (m_tdata[23:22] != want.error_code)
                        report_mismatch("error_code", m_tdata[23:22], want.error_code);
                    if (m_tdata[24] != want.parse_done)
                        report_mismatch("parse_done", m_tdata[24], want.parse_done);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = label_byte(s_tdata);
                if (bytes_taken < N_DIRECTED && DIRECTED[bytes_taken].typed)
                begin
                    want.byte_role   = DIRECTED[bytes_taken].role;
                    want.field_value = DIRECTED[bytes_taken].fld;
                end
                pending_words.push_back(want);
                bytes_taken++;
            end
        end
    end

    initial
    begin : sink
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_all_returned();
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int i;
        int n;
        int klen;
        int vlen;
        bit paused;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i].data);

        // hold off until every word is back, then resume into the entry loop
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_all_returned();

        paused = 1'b0;
        n = N_DIRECTED;
        while (n < 1250)
        begin
            calm = ((n / 150) % 4) == 3;
            if (!paused && n > 650)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait_all_returned();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 8)
            begin
                send_byte(8'($urandom_range(1, 254)));
                unknown_sent++;
                n++;
            end
            else
            begin
                klen = pick_len();
                vlen = pick_len();
                if (klen > longest_len)
                    longest_len = klen;
                if (vlen > longest_len)
                    longest_len = vlen;
                send_byte(TYPE_STRING);
                send_byte(8'(klen));
                repeat (klen) send_byte(8'($urandom_range(0, 255)));
                send_byte(8'(vlen));
                repeat (vlen) send_byte(8'($urandom_range(0, 255)));
                entries_sent++;
                n += 3 + klen + vlen;
            end
        end
        calm = 1'b0;

        // end marker, then trailing bytes that must come back as ignored
        send_byte(END_MARK);
        repeat (8) send_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        for (i = 0; i < 20000 && pending_words.size() != 0; i++)
            @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch("words never returned", pending_words.size(), 0);
        repeat (8) @(posedge clk);

        $display("bytes taken %0d, words checked %0d, string entries %0d, unknown types %0d",
                 bytes_taken, words_checked, entries_sent, unknown_sent);
        $display("longest key or value %0d bytes, mismatches %0d", longest_len, err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
